@@ hdl/rit_pkg.sv @@
// ----------------------------------------------------------------------------
// rit_pkg
// Types, operation codes and helpers shared by the repeating interval timer.
// ----------------------------------------------------------------------------
`default_nettype none

package rit_pkg;

    localparam int unsigned TIME_W           = 32;
    localparam int unsigned REMAIN_W         = 31;
    localparam int unsigned MAX_DURATION_DEF = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ONE_SHOT = 2'd1,
        OP_REPEAT   = 2'd2,
        OP_POLL     = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [TIME_W-1:0]   lead_ms;
        logic [TIME_W-1:0]   period_ms;
    } item_t;

    typedef struct packed {
        logic                expired;
        logic                running;
        logic [REMAIN_W-1:0] remaining;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic [TIME_W-1:0]   expiry_time;
        logic [TIME_W-1:0]   repeat_interval;
    } timer_state_t;

    function automatic logic [TIME_W-1:0] clamp_dur(
        input logic [TIME_W-1:0] d,
        input logic [TIME_W-1:0] max_dur
    );
        return (d > max_dur) ? max_dur : d;
    endfunction

    // zero expiry means stopped, so a computed zero becomes one
    function automatic logic [TIME_W-1:0] fix_zero(input logic [TIME_W-1:0] t);
        return (t == '0) ? TIME_W'(1) : t;
    endfunction

endpackage

`default_nettype wire

@@ hdl/repeating_interval_timer.sv @@
// ----------------------------------------------------------------------------
// repeating_interval_timer
// Millisecond one-shot / repeating timer on a wrapping 32-bit time base.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item. op selects tick, start
//                    one-shot, start repeating or poll.
//   result channel : result_valid / result_stall / result. exactly one result
//                    beat per item beat, in order.
//   An item beat is taken into the item register, then the step logic
//   updates the timer state and loads the result register. Throughput is
//   one item per cycle while the receiver does not stall, set by the single
//   state update per cycle; the item register and the result register keep
//   both sides moving together.
//   Reset clears time base, expiry and repeat interval, and empties both
//   registers. When the receiver stalls, the result holds; the item register
//   still takes one more beat, after which item_stall rises until the result
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module repeating_interval_timer #(
    parameter logic [31:0] MAX_DURATION = rit_pkg::MAX_DURATION_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              item_valid,
    output logic             item_stall,
    input  rit_pkg::item_t   item,
    output logic             result_valid,
    input  wire              result_stall,
    output rit_pkg::result_t result
);
    import rit_pkg::*;

    logic         item_v_reg;
    logic         item_v_next;
    item_t        item_reg;
    logic         res_v_reg;
    logic         res_v_next;
    result_t      res_reg;
    timer_state_t state_reg;
    timer_state_t state_next;
    result_t      step_res;
    logic         accept;
    logic         step_en;

    rit_step #(
        .MAX_DURATION (MAX_DURATION)
    ) u_step (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    assign step_en    = item_v_reg && (!res_v_reg || !result_stall);
    assign item_stall = item_v_reg && res_v_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        item_v_next = item_v_reg;
        if (accept)
        begin
            item_v_next = 1'b1;
        end
        else if (step_en)
        begin
            item_v_next = 1'b0;
        end

        res_v_next = res_v_reg;
        if (step_en)
        begin
            res_v_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            res_v_reg  <= 1'b0;
            state_reg  <= '0;
        end
        else
        begin
            item_v_reg <= item_v_next;
            res_v_reg  <= res_v_next;
            if (step_en)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

@@ hdl/rit_step.sv @@
// ----------------------------------------------------------------------------
// rit_step
// Next timer state and result for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_step #(
    parameter logic [31:0] MAX_DURATION = rit_pkg::MAX_DURATION_DEF
) (
    input  rit_pkg::item_t        item,
    input  rit_pkg::timer_state_t cur,
    output rit_pkg::timer_state_t nxt,
    output rit_pkg::result_t      res
);
    import rit_pkg::*;

    logic [TIME_W-1:0] first_c;
    logic [TIME_W-1:0] diff;
    logic              diff_pos;
    logic [TIME_W-1:0] sum;
    logic [TIME_W-1:0] exp_from_exp;
    logic [TIME_W-1:0] exp_from_now;
    logic [TIME_W-1:0] exp_start;
    logic [TIME_W-1:0] diff_out;
    logic              running;

    always_comb
    begin
        first_c      = clamp_dur(item.lead_ms, MAX_DURATION);
        diff         = cur.expiry_time - cur.now_ms;
        diff_pos     = (diff != '0) && !diff[TIME_W-1];
        sum          = cur.repeat_interval + diff;
        // reload relative to the old expiry, or to now when overdue too far
        exp_from_exp = cur.expiry_time + cur.repeat_interval;
        exp_from_now = cur.now_ms + cur.repeat_interval;
        exp_start    = cur.now_ms + first_c;

        nxt         = cur;
        res.expired = 1'b0;

        unique case (item.op)
            OP_TICK:
            begin
                nxt.now_ms = cur.now_ms + TIME_W'(1);
            end
            OP_ONE_SHOT, OP_REPEAT:
            begin
                if (first_c != '0)
                begin
                    nxt.expiry_time     = fix_zero(exp_start);
                    nxt.repeat_interval = '0;
                end
                else
                begin
                    nxt.expiry_time = '0;
                end
                if (item.op == OP_REPEAT)
                begin
                    nxt.repeat_interval = clamp_dur(item.period_ms, MAX_DURATION);
                end
            end
            OP_POLL:
            begin
                if ((cur.expiry_time != '0) && !diff_pos)
                begin
                    res.expired     = 1'b1;
                    nxt.expiry_time = '0;
                    if (cur.repeat_interval != '0)
                    begin
                        if (sum[TIME_W-1])
                        begin
                            nxt.expiry_time = fix_zero(exp_from_now);
                        end
                        else if (sum != '0)
                        begin
                            nxt.expiry_time = fix_zero(exp_from_exp);
                        end
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        diff_out      = nxt.expiry_time - nxt.now_ms;
        running       = (nxt.expiry_time != '0) && (diff_out != '0) && !diff_out[TIME_W-1];
        res.running   = running;
        res.remaining = running ? diff_out[REMAIN_W-1:0] : '0;
    end

endmodule

`default_nettype wire

@@ hdl/rit_checker.sv @@
// ----------------------------------------------------------------------------
// rit_checker
// Port-level checks for the repeating interval timer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rit_checker (
    input wire              clk,
    input wire              rst_n,
    input wire              item_valid,
    input wire              item_stall,
    input rit_pkg::item_t   item,
    input wire              result_valid,
    input wire              result_stall,
    input rit_pkg::result_t result
);
    import rit_pkg::*;

    // a stalled result beat stays offered
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // remaining is nonzero exactly when the timer runs
    a_running_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.running == (result.remaining != '0)))
        else $error("running flag disagrees with remaining");

    // input only backs up when a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled with no result pending");

    // an item beat with an empty result side yields a result once it has passed the item and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && !result_valid |=> ##1 result_valid)
        else $error("accepted item produced no result");

endmodule

bind repeating_interval_timer rit_checker u_rit_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the repeating interval timer: a directed opening
// on the expiry, clamping and overdue-reload corners, then bursts of timer
// starts followed by ticks and polls or by short random runs, with random
// idling on both channels and one long receiver hold-off. Each result beat
// is checked against a cycle-free timer model held in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import rit_pkg::*;

    class timer_scoreboard;
        logic [31:0] now_ms;
        logic [31:0] expiry_ms;
        logic [31:0] reload_ms;
        result_t     due_results[$];
        int unsigned failures;
        int unsigned mismatches;
        int unsigned checked;
        int unsigned expiries;
        int unsigned reloads;

        function new();
            now_ms     = '0;
            expiry_ms  = '0;
            reload_ms  = '0;
            failures   = 0;
            mismatches = 0;
            checked    = 0;
            expiries   = 0;
            reloads    = 0;
        endfunction

        function logic [31:0] limit_ms(input logic [31:0] d);
            return (d > 32'(MAX_DURATION_DEF)) ? 32'(MAX_DURATION_DEF) : d;
        endfunction

        function void arm(input logic [31:0] d);
            if (d != '0)
            begin
                reload_ms = '0;
                expiry_ms = now_ms + limit_ms(d);
                // zero is the stopped marker
                if (expiry_ms == '0)
                    expiry_ms = 32'd1;
            end
            else
            begin
                expiry_ms = '0;
            end
        endfunction

        function bit take_expiry();
            logic [31:0] diff;
            logic [31:0] keep;
            logic [31:0] sum;
            if (expiry_ms == '0)
                return 1'b0;
            diff = expiry_ms - now_ms;
            if (diff != '0 && !diff[31])
                return 1'b0;
            expiry_ms = '0;
            if (reload_ms != '0)
            begin
                keep = reload_ms;
                // overdue amount shortens the reload, but never below zero
                sum = keep + diff;
                if (sum[31])
                    sum = keep;
                arm(sum);
                reload_ms = keep;
                reloads++;
            end
            return 1'b1;
        endfunction

        function void accept_item(input item_t it);
            logic [31:0] diff;
            result_t     want;
            want = '0;
            case (it.op)
                OP_TICK:     now_ms = now_ms + 32'd1;
                OP_ONE_SHOT: arm(it.lead_ms);
                OP_REPEAT:
                begin
                    arm(limit_ms(it.lead_ms));
                    reload_ms = limit_ms(it.period_ms);
                end
                default:     want.expired = take_expiry();
            endcase
            diff = expiry_ms - now_ms;
            if (expiry_ms != '0 && diff != '0 && !diff[31])
            begin
                want.running   = 1'b1;
                want.remaining = diff[30:0];
            end
            if (want.expired)
                expiries++;
            due_results.push_back(want);
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                failures++;
                $display("unexpected result beat: expired=%0b running=%0b remaining=%0d",
                         got.expired, got.running, got.remaining);
                return;
            end
            want = due_results.pop_front();
            if (got.expired !== want.expired || got.running !== want.running ||
                got.remaining !== want.remaining)
            begin
                failures++;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("beat %0d: want expired=%0b running=%0b remaining=%0d",
                             checked, want.expired, want.running, want.remaining);
                    $display("beat %0d: got  expired=%0b running=%0b remaining=%0d",
                             checked, got.expired, got.running, got.remaining);
                end
            end
            checked++;
        endfunction
    endclass

    localparam int unsigned RANDOM_BEATS = 1700;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    result_stall = 1'b0;
    logic    item_stall;
    logic    result_valid;
    result_t result;

    timer_scoreboard sb;
    bit              calm        = 1'b0;
    bit              held_long   = 1'b0;
    int unsigned     sent        = 0;
    int unsigned     held_cycles = 0;
    int unsigned     blocked     = 0;

    repeating_interval_timer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 80)
            return $urandom_range(1, 12);
        else if (r < 90)
            return $urandom;
        else if (r < 95)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h7FFF_FFFE;
            endcase
        end
        return $urandom_range(13, 100);
    endfunction

    task automatic send_item(input op_t op, input logic [31:0] a, input logic [31:0] b);
        item_t       it;
        int unsigned gap;
        it.op        = op;
        it.lead_ms   = a;
        it.period_ms = b;
        gap = calm ? 0 : idle_len();
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.accept_item(it);
        sent++;
    endtask

    task automatic tick_run(input int unsigned n);
        repeat (n)
            send_item(OP_TICK, $urandom, $urandom);
    endtask

    // a start followed by ticks and polls, or now and then a short run of noise
    task automatic run_burst();
        int unsigned len;
        op_t         op;
        if ($urandom_range(0, 99) < 85)
        begin
            op = ($urandom_range(0, 1) != 0) ? OP_REPEAT : OP_ONE_SHOT;
            send_item(op, pick_duration(), pick_duration());
            len = $urandom_range(3, 30);
            repeat (len)
            begin
                op = ($urandom_range(0, 9) < 7) ? OP_TICK : OP_POLL;
                send_item(op, $urandom, $urandom);
            end
        end
        else
        begin
            len = $urandom_range(1, 8);
            repeat (len)
            begin
                op = op_t'($urandom_range(0, 3));
                if ($urandom_range(0, 1) != 0)
                    send_item(op, $urandom, $urandom);
                else
                    send_item(op, pick_duration(), pick_duration());
            end
        end
    endtask

    // receiver: checks each beat, then picks the stall for the next edge
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                sb.check_result(result);
            if (item_valid && item_stall)
                blocked++;
            if (hold_left != 0)
                hold_left--;
            if (hold_left == 0)
            begin
                if (!held_long && sb.checked >= 700)
                begin
                    // long hold-off so the block fills and pushes back
                    held_long   = 1'b1;
                    hold_left   = HOLD_CYCLES;
                    held_cycles = HOLD_CYCLES;
                end
                else if (!calm)
                begin
                    hold_left = idle_len();
                end
            end
            result_stall <= (hold_left != 0);
        end
    end

    initial
    begin
        #(15_000_000);
        $display("timeout waiting on the timer");
        $display("** repeating_interval_timer: FAILED **");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stopped timer, zero start, expiry reported once
        send_item(OP_POLL,     32'd0, 32'd0);
        send_item(OP_ONE_SHOT, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_ONE_SHOT, 32'd1, 32'd0);
        send_item(OP_TICK,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_POLL,     32'd0, 32'd0);
        send_item(OP_POLL,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // clamping, and a repeating start with a zero first interval
        send_item(OP_ONE_SHOT, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_REPEAT,   32'd0, 32'hFFFF_FFFF);
        send_item(OP_POLL,     32'd0, 32'd0);
        // overdue by one: reload shortened
        send_item(OP_REPEAT,   32'd2, 32'd3);
        tick_run(3);
        send_item(OP_POLL,     32'd0, 32'd0);
        // overdue by the whole interval: timer stops, repeat kept
        send_item(OP_REPEAT,   32'd1, 32'd2);
        tick_run(3);
        send_item(OP_POLL,     32'd0, 32'd0);
        // overdue past the interval: adjustment dropped
        send_item(OP_REPEAT,   32'd1, 32'd1);
        tick_run(3);
        send_item(OP_POLL,     32'd0, 32'd0);
        send_item(OP_ONE_SHOT, 32'd5, 32'h8000_0000);

        while (sent < RANDOM_BEATS + 25)
        begin
            calm = ((sent / 150) % 4 == 2);
            run_burst();
        end
        item_valid <= 1'b0;
        calm = 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d beats: %0d expiries seen, %0d repeat reloads, %0d mismatches",
                 sent, sb.expiries, sb.reloads, sb.mismatches);
        $display("receiver held off %0d cycles in one stretch, input stalled for %0d cycles",
                 held_cycles, blocked);
        if (sb.failures == 0)
            $display("** repeating_interval_timer: PASSED **");
        else
            $display("** repeating_interval_timer: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
